>>> rtl/ldf_pkg.sv
// Shared types and constants of the breathing LED fader.
package ldf_pkg;

  localparam int unsigned LevelW   = 8;
  localparam int unsigned ElapsedW = 17;
  localparam int unsigned DelayW   = 16;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned PaddrW   = 3;
  localparam int unsigned PdataW   = 32;

  localparam logic [LevelW-1:0]   LevelMax    = 8'd255;
  localparam logic [ElapsedW-1:0] ElapsedMax  = 17'h1FFFF;
  localparam logic [DelayW-1:0]   StepDelayRst = 16'd10;

  // Register index taken from the word-aligned byte address.
  localparam logic RegStepDelay = 1'b0;

  typedef enum logic [ModeW-1:0] {
    MODE_START   = 3'd0,
    MODE_RISING  = 3'd1,
    MODE_FALLING = 3'd2,
    MODE_OFF     = 3'd3,
    MODE_ON      = 3'd4
  } mode_e;

  typedef enum logic [CmdW-1:0] {
    CMD_NONE   = 2'd0,
    CMD_ON     = 2'd1,
    CMD_OFF    = 2'd2,
    CMD_TOGGLE = 2'd3
  } cmd_e;

  // Contents of the input register as seen by the step logic.
  typedef struct packed {
    logic valid;
    logic tick;
    cmd_e command;
  } stage_t;

endpackage

>>> rtl/ldf_if.sv
// Valid/ready channel interfaces for the fader's input and result transactions.
interface ldf_in_if;
  logic                        valid;
  logic                        ready;
  logic                        tick;
  logic [ldf_pkg::CmdW-1:0]    command;

  modport source (output valid, output tick, output command, input ready);
  modport sink   (input valid, input tick, input command, output ready);
endinterface

interface ldf_out_if;
  logic                        valid;
  logic                        ready;
  logic [ldf_pkg::LevelW-1:0]  brightness;
  logic [ldf_pkg::ModeW-1:0]   mode;

  modport source (output valid, output brightness, output mode, input ready);
  modport sink   (input valid, input brightness, input mode, output ready);
endinterface

>>> rtl/ldf_apb_regs.sv
// APB configuration register file holding the brightness step delay.
module ldf_apb_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ldf_pkg::PaddrW-1:0]   paddr,
  input  logic [ldf_pkg::PdataW-1:0]   pwdata,
  output logic [ldf_pkg::PdataW-1:0]   prdata,
  output logic                         pready,
  output logic [ldf_pkg::DelayW-1:0]   step_delay_o
);

  logic [ldf_pkg::DelayW-1:0] step_delay_q, step_delay_d;
  logic                       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready
                  && (paddr[2] == ldf_pkg::RegStepDelay);

  always_comb begin
    step_delay_d = step_delay_q;
    if (wr_en) begin
      step_delay_d = pwdata[ldf_pkg::DelayW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_delay_q <= ldf_pkg::StepDelayRst;
    end else begin
      step_delay_q <= step_delay_d;
    end
  end

  // Only the first word decodes; every other address reads as zero.
  assign prdata = (paddr[2] == ldf_pkg::RegStepDelay)
                  ? {{(ldf_pkg::PdataW - ldf_pkg::DelayW){1'b0}}, step_delay_q}
                  : '0;

  assign step_delay_o = step_delay_q;

endmodule

>>> rtl/ldf_in_reg.sv
// Input register stage capturing one tick/command transaction per cycle while in_s.ready is high.
module ldf_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  ldf_in_if.sink          in_s,
  input  logic            advance_i,
  output ldf_pkg::stage_t stage_o
);

  logic                 valid_q, valid_d;
  logic                 tick_q;
  ldf_pkg::cmd_e        command_q;
  logic                 load;

  assign in_s.ready = !valid_q || advance_i;
  assign load       = in_s.valid && in_s.ready;

  always_comb begin
    valid_d = valid_q;
    if (in_s.ready) begin
      valid_d = in_s.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tick_q    <= in_s.tick;
      command_q <= ldf_pkg::cmd_e'(in_s.command);
    end
  end

  assign stage_o.valid   = valid_q;
  assign stage_o.tick    = tick_q;
  assign stage_o.command = command_q;

endmodule

>>> rtl/ldf_fader.sv
// Fader state, single-pass step logic and result register.
module ldf_fader (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ldf_pkg::stage_t             stage_i,
  input  logic [ldf_pkg::DelayW-1:0]  step_delay_i,
  output logic                        advance_o,
  ldf_out_if.source                   out_s
);

  ldf_pkg::mode_e                 mode_q, mode_d, mode_cmd;
  logic [ldf_pkg::LevelW-1:0]     level_q, level_d;
  logic [ldf_pkg::ElapsedW-1:0]   elapsed_q, elapsed_d, elapsed_tick;
  logic                           due;
  logic                           fire;
  logic                           out_valid_q, out_valid_d;
  logic [ldf_pkg::LevelW-1:0]     out_bright_q;
  ldf_pkg::mode_e                 out_mode_q;

  assign advance_o = !out_valid_q || out_s.ready;
  assign fire      = stage_i.valid && advance_o;

  // Command first, then the saturating millisecond count.
  always_comb begin
    mode_cmd = mode_q;
    unique case (stage_i.command)
      ldf_pkg::CMD_NONE:   mode_cmd = mode_q;
      ldf_pkg::CMD_ON:     mode_cmd = (mode_q == ldf_pkg::MODE_OFF) ? ldf_pkg::MODE_ON : mode_q;
      ldf_pkg::CMD_OFF:    mode_cmd = ldf_pkg::MODE_OFF;
      ldf_pkg::CMD_TOGGLE: mode_cmd = (mode_q == ldf_pkg::MODE_OFF) ? ldf_pkg::MODE_ON
                                                                   : ldf_pkg::MODE_OFF;
      default:             mode_cmd = mode_q;
    endcase
  end

  assign elapsed_tick = (stage_i.tick && (elapsed_q != ldf_pkg::ElapsedMax))
                        ? elapsed_q + 1'b1 : elapsed_q;
  assign due = elapsed_tick > {1'b0, step_delay_i};

  always_comb begin
    mode_d    = mode_cmd;
    level_d   = level_q;
    elapsed_d = elapsed_tick;
    unique case (mode_cmd)
      ldf_pkg::MODE_RISING: begin
        if (due && (level_q != ldf_pkg::LevelMax)) begin
          level_d   = level_q + 1'b1;
          elapsed_d = '0;
        end else if (level_q == ldf_pkg::LevelMax) begin
          mode_d = ldf_pkg::MODE_FALLING;
        end
      end
      ldf_pkg::MODE_FALLING: begin
        if (due && (level_q >= 8'd2)) begin
          level_d   = level_q - 1'b1;
          elapsed_d = '0;
        end else if (level_q == 8'd1) begin
          mode_d = ldf_pkg::MODE_RISING;
        end
      end
      ldf_pkg::MODE_OFF: begin
        if (due && (level_q != '0)) begin
          level_d   = level_q - 1'b1;
          elapsed_d = '0;
        end
      end
      ldf_pkg::MODE_ON: begin
        mode_d = (level_q != ldf_pkg::LevelMax) ? ldf_pkg::MODE_RISING
                                                : ldf_pkg::MODE_FALLING;
      end
      default: begin
        // Start mode, and any unused code, restarts the ramp at the bottom.
        elapsed_d = '0;
        level_d   = 8'd1;
        mode_d    = ldf_pkg::MODE_RISING;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance_o) begin
      out_valid_d = stage_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ldf_pkg::MODE_START;
      level_q     <= '0;
      elapsed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        mode_q    <= mode_d;
        level_q   <= level_d;
        elapsed_q <= elapsed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_bright_q <= level_d;
      out_mode_q   <= mode_d;
    end
  end

  assign out_s.valid      = out_valid_q;
  assign out_s.brightness = out_bright_q;
  assign out_s.mode       = out_mode_q;

endmodule

>>> rtl/led_breathing_fader.sv
// Top level of the breathing LED fader: input stage, fader core and APB registers.
//
// Each input transaction on in_s is one pass of the control step: a millisecond
// tick flag and a command (none, on, off, toggle). Each accepted input gives
// exactly one result transaction on out_s carrying the brightness and the mode
// after that pass. The brightness ramps 1 up to 255 and back to 1, one step each
// time the elapsed milliseconds exceed step_delay; off fades to 0 and holds.
//
// A transaction accepted at one clock edge is captured in the input register,
// runs through the step logic and is then written into the result register.
// Throughput is one transaction per cycle while the receiver does not stall,
// set by the single input register and result register.
// While the receiver stalls, the result register holds and the input register
// can still take one further transaction; in_s.ready falls only when both are
// full.
//
// Reset clears both stages, puts the fader in start mode with level and elapsed
// time at zero, and sets step_delay to 10. step_delay is written through the APB
// port at byte address 0 and should be changed only while the block is idle.
module led_breathing_fader (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ldf_in_if.sink                       in_s,
  ldf_out_if.source                    out_s,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ldf_pkg::PaddrW-1:0]   paddr,
  input  logic [ldf_pkg::PdataW-1:0]   pwdata,
  output logic [ldf_pkg::PdataW-1:0]   prdata,
  output logic                         pready
);

  logic [ldf_pkg::DelayW-1:0] step_delay;
  logic                       advance;
  ldf_pkg::stage_t            stage;

  ldf_apb_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .step_delay_o (step_delay)
  );

  ldf_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_s      (in_s),
    .advance_i (advance),
    .stage_o   (stage)
  );

  ldf_fader u_fader (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .stage_i      (stage),
    .step_delay_i (step_delay),
    .advance_o    (advance),
    .out_s        (out_s)
  );

  // Start and on are transient modes: every pass leaves them straight away.
  a_no_transient_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_s.valid |-> (out_s.mode != ldf_pkg::MODE_START) && (out_s.mode != ldf_pkg::MODE_ON))
    else $error("transient mode reported in a result");

  // The falling ramp turns round at one and never reaches zero brightness. A rising
  // ramp may start from zero when the lamp is turned back on after a full fade.
  a_ramp_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_s.valid && (out_s.mode == ldf_pkg::MODE_FALLING) |-> out_s.brightness != '0)
    else $error("falling ramp brightness at zero");

  // A held input transaction moves on as soon as the result register frees up.
  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage.valid && !out_s.valid |=> out_s.valid)
    else $error("input stage did not advance into an empty result register");

endmodule
